>>> hw/rtl/imc_pkg.sv
// Shared types, constants and mod-97 helper functions for the IBAN checker.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package imc_pkg;

	localparam int CHAR_W = 8;
	localparam int CFG_W = 7;
	localparam int REM_W = 7;
	localparam int VAL_W = 6;
	localparam int STATUS_W = 2;

	localparam int DEF_HEAD_CHARS = 4;
	localparam int DEF_COUNT_BOUND = 127;
	localparam int DEF_QUEUE_DEPTH = 4;

	localparam logic [CFG_W-1:0] MIN_LENGTH_RESET = 7'd15;
	localparam logic [CFG_W-1:0] MAX_LENGTH_RESET = 7'd34;

	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
	localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;
	localparam logic [CHAR_W-1:0] LETTER_BIAS = 8'd10;

	localparam logic [REM_W-1:0] REM_ONE = 7'd1;

	// Register indexes on the configuration port.
	localparam logic REG_MIN_LENGTH = 1'b0;
	localparam logic REG_MAX_LENGTH = 1'b1;

	typedef enum logic [1:0] {
		K_LETTER,
		K_DIGIT,
		K_SPACE,
		K_BAD
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_VALID      = 2'd0,
		ST_BAD_LENGTH = 2'd1,
		ST_BAD_CHAR   = 2'd2,
		ST_MISMATCH   = 2'd3
	} status_t;

	// One classified character as it travels from the front to the back.
	typedef struct packed {
		kind_t             kind;
		logic [VAL_W-1:0]  val;
		logic              head;
		logic              last;
		logic              len_bad;
	} char_item_t;

	// Remainder modulo 97 of a value below 97 * 97 + 97. The quotient comes from a
	// reciprocal that never overestimates, so one correction step is enough.
	function automatic logic [REM_W-1:0] mod97(input logic [13:0] x);
		logic [23:0] prod;
		logic [6:0]  quot;
		logic [13:0] rem;
		prod = {10'd0, x} * 24'd675;
		quot = prod[22:16];
		rem = x - ({7'd0, quot} * 14'd97);
		if (rem >= 14'd97) begin
			rem = rem - 14'd97;
		end
		return rem[REM_W-1:0];
	endfunction

	// Folds one character into a remainder. A letter is two decimal digits, and
	// 100 is 3 modulo 97; a digit is one decimal digit.
	function automatic logic [REM_W-1:0] fold_rem(input logic [REM_W-1:0] rem,
			input kind_t kind, input logic [VAL_W-1:0] val);
		logic [13:0] x;
		x = {7'd0, rem};
		unique case (kind)
			K_LETTER: x = ({7'd0, rem} * 14'd3) + {8'd0, val};
			K_DIGIT:  x = ({7'd0, rem} * 14'd10) + {8'd0, val};
			default:  x = {7'd0, rem};
		endcase
		return mod97(x);
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/imc_front.sv
// Front end of the IBAN checker: accepts characters, classifies them and
// tracks the string position. Depends on imc_pkg.
`default_nettype none

module imc_front #(
	parameter int HEAD_CHARS = imc_pkg::DEF_HEAD_CHARS,
	parameter int COUNT_BOUND = imc_pkg::DEF_COUNT_BOUND
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [imc_pkg::CHAR_W-1:0] s_tdata,
	input  wire logic                       s_tlast,
	input  wire logic [imc_pkg::CFG_W-1:0]  min_length,
	input  wire logic [imc_pkg::CFG_W-1:0]  max_length,
	output logic                            item_valid,
	input  wire logic                       item_ready,
	output imc_pkg::char_item_t             item
);
	import imc_pkg::*;

	localparam int CNT_W = $clog2(COUNT_BOUND + 1);
	localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam logic [CNT_W-1:0] BOUND = CNT_W'(COUNT_BOUND);

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  len;
	logic [CHAR_W-1:0] upper;
	logic [CHAR_W-1:0] letter_val;
	logic [CHAR_W-1:0] digit_val;
	logic              accept;

	assign s_tready = item_ready;
	assign item_valid = s_tvalid;
	assign accept = s_tvalid && item_ready;

	// Length including this character, held at the bound.
	assign len = (count_q == BOUND) ? BOUND : count_q + CNT_W'(1);

	always_comb begin
		upper = s_tdata;
		if (s_tdata >= CH_LOWER_A && s_tdata <= CH_LOWER_Z) begin
			upper = s_tdata - CASE_OFFSET;
		end
		letter_val = upper - CH_UPPER_A + LETTER_BIAS;
		digit_val = upper - CH_ZERO;

		item.val = '0;
		if (upper >= CH_UPPER_A && upper <= CH_UPPER_Z) begin
			item.kind = K_LETTER;
			item.val = letter_val[VAL_W-1:0];
		end else if (upper >= CH_ZERO && upper <= CH_NINE) begin
			item.kind = K_DIGIT;
			item.val = digit_val[VAL_W-1:0];
		end else if (upper == CH_SPACE) begin
			item.kind = K_SPACE;
		end else begin
			item.kind = K_BAD;
		end
		item.head = count_q < CNT_W'(HEAD_CHARS);
		item.last = s_tlast;
		item.len_bad = (CMP_W'(len) < CMP_W'(min_length)) ||
			(CMP_W'(len) > CMP_W'(max_length));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= s_tlast ? '0 : len;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/imc_queue.sv
// Small register FIFO that decouples the front end from the fold pipeline.
// Generic in width and depth; takes its default depth from imc_pkg.
`default_nettype none

module imc_queue #(
	parameter int WIDTH = 1,
	parameter int DEPTH = imc_pkg::DEF_QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [WIDTH-1:0] in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [WIDTH-1:0]      out_data
);
	import imc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             push;
	logic             pop;

	assign in_ready = fill_q != CNT_W'(DEPTH);
	assign out_valid = fill_q != '0;
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;
	assign out_data = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   fill_q <= fill_q + CNT_W'(1);
				2'b01:   fill_q <= fill_q - CNT_W'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/imc_back.sv
// Back end of the IBAN checker: folds classified characters into the mod-97
// remainders and grades each finished string. Depends on imc_pkg.
`default_nettype none

module imc_back (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   item_valid,
	output logic                        item_ready,
	input  wire imc_pkg::char_item_t    item,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic                        is_valid,
	output logic [imc_pkg::STATUS_W-1:0] status
);
	import imc_pkg::*;

	// The leading characters are folded on their own, together with the power of
	// ten they span; at the end of the string they are appended in one step as
	// rem * scale + head_rem.
	logic [REM_W-1:0] rem_q;
	logic [REM_W-1:0] head_rem_q;
	logic [REM_W-1:0] head_scale_q;
	logic             bad_q;

	logic [REM_W-1:0] rem_nx;
	logic [REM_W-1:0] head_rem_nx;
	logic [REM_W-1:0] head_scale_nx;
	logic             bad_nx;

	logic             valid_s2;
	logic [REM_W-1:0] rem_s2;
	logic [REM_W-1:0] head_rem_s2;
	logic [REM_W-1:0] head_scale_s2;
	logic             bad_s2;
	logic             len_bad_s2;

	logic             valid_s3;
	logic [13:0]      total_s3;
	logic             bad_s3;
	logic             len_bad_s3;

	logic             out_valid_q;
	status_t          status_q;
	status_t          status_nx;
	logic             adv;
	logic             pop;

	// The whole pipeline moves when the output register is free or being taken.
	assign adv = !out_valid_q || m_tready;
	assign item_ready = adv;
	assign pop = item_valid && adv;

	always_comb begin
		rem_nx = rem_q;
		head_rem_nx = head_rem_q;
		head_scale_nx = head_scale_q;
		bad_nx = bad_q;
		if (item.head) begin
			head_rem_nx = fold_rem(head_rem_q, item.kind, item.val);
			head_scale_nx = fold_rem(head_scale_q, item.kind, '0);
			if (item.kind == K_SPACE || item.kind == K_BAD) begin
				bad_nx = 1'b1;
			end
		end else begin
			rem_nx = fold_rem(rem_q, item.kind, item.val);
			if (item.kind == K_BAD) begin
				bad_nx = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			head_rem_q <= '0;
			head_scale_q <= REM_ONE;
			bad_q <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s2 <= pop && item.last;
			valid_s3 <= valid_s2;
			out_valid_q <= valid_s3;
			if (pop) begin
				if (item.last) begin
					rem_q <= '0;
					head_rem_q <= '0;
					head_scale_q <= REM_ONE;
					bad_q <= 1'b0;
				end else begin
					rem_q <= rem_nx;
					head_rem_q <= head_rem_nx;
					head_scale_q <= head_scale_nx;
					bad_q <= bad_nx;
				end
			end
		end
	end

	always_comb begin
		priority if (len_bad_s3) begin
			status_nx = ST_BAD_LENGTH;
		end else if (bad_s3) begin
			status_nx = ST_BAD_CHAR;
		end else if (mod97(total_s3) != REM_ONE) begin
			status_nx = ST_MISMATCH;
		end else begin
			status_nx = ST_VALID;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s2 <= rem_nx;
			head_rem_s2 <= head_rem_nx;
			head_scale_s2 <= head_scale_nx;
			bad_s2 <= bad_nx;
			len_bad_s2 <= item.len_bad;
			total_s3 <= ({7'd0, rem_s2} * {7'd0, head_scale_s2}) + {7'd0, head_rem_s2};
			bad_s3 <= bad_s2;
			len_bad_s3 <= len_bad_s2;
			status_q <= status_nx;
		end
	end

	assign m_tvalid = out_valid_q;
	assign status = status_q;
	assign is_valid = status_q == ST_VALID;

endmodule

`default_nettype wire

>>> hw/rtl/iban_mod97_checker.sv
// Top level of the streaming IBAN checker: configuration registers and the
// front end, queue and fold pipeline. Depends on imc_pkg, imc_front,
// imc_queue and imc_back.
//
// Usage:
// The slave stream takes one byte of the IBAN string per item in s_tdata, with
// s_tlast set on the final byte. For each string the master stream gives one
// item: is_valid and a status code (valid, bad length, bad character,
// checksum mismatch). Bytes without s_tlast give no output.
// Throughput is one byte per cycle while the queue has room, with no gap
// between strings. A result is registered by the fold stage, the append
// multiply and the final reduction in the back end before it is on m_tvalid.
// Once a result waits on m_tready the back end stops; the front end keeps
// taking bytes until the queue of QUEUE_DEPTH entries is full, then drops
// s_tready.
// The APB port holds min_length (address 0) and max_length (address 4).
// Write them only while no string is in flight. Reset clears the position
// counter, the remainders and all valid flags and loads the default lengths
// 15 and 34; the block takes bytes from the first cycle after reset.
`default_nettype none

module iban_mod97_checker #(
	parameter int HEAD_CHARS = imc_pkg::DEF_HEAD_CHARS,
	parameter int COUNT_BOUND = imc_pkg::DEF_COUNT_BOUND,
	parameter int QUEUE_DEPTH = imc_pkg::DEF_QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] char_code
	input  wire logic        s_tlast,   // last_char
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata    // [0] is_valid, [2:1] status, [7:3] zero
);
	import imc_pkg::*;

	localparam int ITEM_W = $bits(char_item_t);

	logic [CFG_W-1:0]    min_length_q;
	logic [CFG_W-1:0]    max_length_q;
	logic                wr_en;

	logic                front_valid;
	logic                front_ready;
	char_item_t          front_item;
	logic                back_valid;
	logic                back_ready;
	logic [ITEM_W-1:0]   back_bits;
	char_item_t          back_item;
	logic                is_valid;
	logic [STATUS_W-1:0] status;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q <= MIN_LENGTH_RESET;
			max_length_q <= MAX_LENGTH_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_MIN_LENGTH: min_length_q <= pwdata[CFG_W-1:0];
				REG_MAX_LENGTH: max_length_q <= pwdata[CFG_W-1:0];
				default:        min_length_q <= min_length_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MIN_LENGTH: prdata = 32'(min_length_q);
			REG_MAX_LENGTH: prdata = 32'(max_length_q);
			default:        prdata = '0;
		endcase
	end

	imc_front #(
		.HEAD_CHARS (HEAD_CHARS),
		.COUNT_BOUND(COUNT_BOUND)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.min_length(min_length_q),
		.max_length(max_length_q),
		.item_valid(front_valid),
		.item_ready(front_ready),
		.item      (front_item)
	);

	imc_queue #(
		.WIDTH(ITEM_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (front_valid),
		.in_ready (front_ready),
		.in_data  (front_item),
		.out_valid(back_valid),
		.out_ready(back_ready),
		.out_data (back_bits)
	);

	assign back_item = char_item_t'(back_bits);

	imc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(back_valid),
		.item_ready(back_ready),
		.item      (back_item),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.is_valid  (is_valid),
		.status    (status)
	);

	assign m_tdata = {5'd0, status, is_valid};

endmodule

`default_nettype wire

>>> hw/rtl/imc_checker.sv
// Port-level assertions for the IBAN checker, bound to its top level.
// Depends on imc_pkg and iban_mod97_checker.
`default_nettype none

module imc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        psel,
	input wire logic        penable,
	input wire logic        pwrite,
	input wire logic [2:0]  paddr,
	input wire logic [31:0] pwdata,
	input wire logic [31:0] prdata,
	input wire logic        pready,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [7:0]  s_tdata,
	input wire logic        s_tlast,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [7:0]  m_tdata
);
	import imc_pkg::*;

	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite && pready;

	// A stalled result keeps its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// A character waiting for acceptance is held unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tlast))
		else $error("input item changed while waiting");

	// The valid flag agrees with the status code.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] == (m_tdata[2:1] == ST_VALID)))
		else $error("is_valid disagrees with status");

	// Padding bits of a result are zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:3] == 5'd0)
		else $error("result padding not zero");

	// A register reads back what was just written to it.
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr ##1 (psel && !pwrite && paddr[2] == $past(paddr[2]))
		|-> prdata == 32'($past(pwdata[CFG_W-1:0])))
		else $error("register read back mismatch");

endmodule

bind iban_mod97_checker imc_checker u_imc_checker (.*);

`default_nettype wire

>>> dv/iban_mod97_checker_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for iban_mod97_checker: streams IBAN strings byte by byte,
// predicts the status of each string and compares it with the master stream.
// Depends on imc_pkg and the iban_mod97_checker RTL.

module iban_mod97_checker_tb;
	import imc_pkg::*;

	localparam int HEAD_N = DEF_HEAD_CHARS;
	localparam int COUNT_MAX = DEF_COUNT_BOUND;
	localparam int DRAIN_CYCLES = 16;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 500000;
	localparam int PHASE_CHARS = 250;

	typedef enum logic {ROW_CHAR, ROW_CFG} row_op_t;

	typedef struct {
		row_op_t    op;
		logic       reg_idx;
		logic [7:0] data;
		logic       last;
		logic       typed;
		status_t    st;
	} stim_row_t;

	typedef struct packed {
		logic    ok;
		status_t st;
	} verdict_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] char_code
	logic        s_tlast;   // last_char
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // [0] is_valid, [2:1] status, [7:3] zero

	// Predictor state and its copy of the length registers.
	logic [6:0]  min_len;
	logic [6:0]  max_len;
	int          char_cnt;
	logic [7:0]  head_buf [HEAD_N];
	int          rem_acc;
	bit          bad_seen;

	verdict_t    verdict_q[$];
	stim_row_t   dir_rows[$];
	logic [7:0]  str_buf[$];

	int  err_cnt = 0;
	int  cycle_cnt = 0;
	int  chars_sent = 0;
	int  strings_sent = 0;
	int  verdicts_seen = 0;
	int  settings_used = 0;
	int  holds_done = 0;
	bit  tx_idle_on = 1'b1;
	bit  tx_burst = 1'b0;
	bit  rx_idle_on = 1'b1;
	bit  rx_hold_req = 1'b0;

	iban_mod97_checker DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Folds one byte into the predicted remainder; returns 0 for a bad byte.
	function automatic bit fold_into_rem(input logic [7:0] c, input bit space_ok);
		logic [7:0] u;
		u = c;
		if (c >= CH_LOWER_A && c <= CH_LOWER_Z) u = c - CASE_OFFSET;
		if (u >= CH_UPPER_A && u <= CH_UPPER_Z) begin
			rem_acc = (rem_acc * 100 + int'(u - CH_UPPER_A) + 10) % 97;
			return 1'b1;
		end
		if (u >= CH_ZERO && u <= CH_NINE) begin
			rem_acc = (rem_acc * 10 + int'(u - CH_ZERO)) % 97;
			return 1'b1;
		end
		return space_ok && (u == CH_SPACE);
	endfunction

	task automatic track_char(input logic [7:0] c, input bit last, input bit typed,
			input status_t typed_st);
		int       held;
		status_t  st;
		verdict_t v;
		if (char_cnt < HEAD_N) head_buf[char_cnt] = c;
		else if (!fold_into_rem(c, 1'b1)) bad_seen = 1'b1;
		if (char_cnt < COUNT_MAX) char_cnt++;
		if (last) begin
			held = (char_cnt < HEAD_N) ? char_cnt : HEAD_N;
			for (int i = 0; i < held; i++)
				if (!fold_into_rem(head_buf[i], 1'b0)) bad_seen = 1'b1;
			if (char_cnt < min_len || char_cnt > max_len) st = ST_BAD_LENGTH;
			else if (bad_seen) st = ST_BAD_CHAR;
			else if (rem_acc != 1) st = ST_MISMATCH;
			else st = ST_VALID;
			v.st = typed ? typed_st : st;
			v.ok = (v.st == ST_VALID);
			verdict_q.push_back(v);
			char_cnt = 0;
			rem_acc = 0;
			bad_seen = 1'b0;
		end
	endtask

	task automatic write_reg(input logic idx, input logic [6:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= {25'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		if (idx == REG_MIN_LENGTH) min_len = value;
		else max_len = value;
	endtask

	task automatic push_char(input logic [7:0] c, input bit last, input bit typed,
			input status_t typed_st);
		int gap;
		gap = (tx_idle_on && !tx_burst) ? $urandom_range(15, 0) : 0;
		if ($urandom_range(39, 0) == 0) tx_idle_on = !tx_idle_on;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		track_char(c, last, typed, typed_st);
		chars_sent++;
	endtask

	// Stops offering items and waits until every pending verdict has come back.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_string();
		foreach (str_buf[i]) push_char(str_buf[i], i == str_buf.size() - 1, 1'b0, ST_VALID);
		strings_sent++;
	endtask

	// Builds a string in str_buf: mostly well-formed IBANs with correct check digits,
	// some corrupted or reordered, a few of pure noise.
	task automatic make_string(input int lo, input int hi);
		int         kind, n, rem, chk, pos;
		logic [7:0] body[$];
		logic [7:0] c;
		str_buf.delete();
		kind = $urandom_range(99, 0);
		if (kind < 8) begin
			n = $urandom_range(12, 1);
			repeat (n) str_buf.push_back(8'($urandom_range(255, 0)));
		end else begin
			if ($urandom_range(24, 0) == 0) n = $urandom_range(140, 65);
			else n = $urandom_range(hi + 2, (lo > 7) ? lo - 3 : 5);
			repeat (2) body.push_back(CH_UPPER_A + 8'($urandom_range(25, 0)));
			repeat (2) body.push_back(CH_ZERO);
			repeat (n - 4) begin
				if ($urandom_range(9, 0) < 6) body.push_back(CH_ZERO + 8'($urandom_range(9, 0)));
				else body.push_back(CH_UPPER_A + 8'($urandom_range(25, 0)));
			end
			// The rearranged string (tail first, then the head with "00") sets the check digits.
			rem = 0;
			for (int i = 0; i < n; i++) begin
				c = body[(i + 4) % n];
				if (c >= CH_UPPER_A) rem = (rem * 100 + int'(c - CH_UPPER_A) + 10) % 97;
				else rem = (rem * 10 + int'(c - CH_ZERO)) % 97;
			end
			chk = 98 - rem;
			body[2] = CH_ZERO + 8'(chk / 10);
			body[3] = CH_ZERO + 8'(chk % 10);
			foreach (body[i]) begin
				c = body[i];
				if (c >= CH_UPPER_A && $urandom_range(7, 0) == 0) c = c + CASE_OFFSET;
				if (i >= 4 && $urandom_range(9, 0) == 0) str_buf.push_back(CH_SPACE);
				str_buf.push_back(c);
			end
			if (kind < 28) begin
				str_buf[$urandom_range(str_buf.size() - 1, 0)] = 8'($urandom_range(255, 0));
			end else if (kind < 34) begin
				pos = $urandom_range(str_buf.size() - 2, 0);
				c = str_buf[pos];
				str_buf[pos] = str_buf[pos + 1];
				str_buf[pos + 1] = c;
			end
		end
	endtask

	task automatic add_byte(input logic [7:0] c, input bit last, input bit typed,
			input status_t st);
		stim_row_t r;
		r.op = ROW_CHAR;
		r.reg_idx = REG_MIN_LENGTH;
		r.data = c;
		r.last = last;
		r.typed = typed;
		r.st = st;
		dir_rows.push_back(r);
	endtask

	task automatic add_text(input string t, input bit ends, input bit typed, input status_t st);
		for (int i = 0; i < t.len(); i++)
			add_byte(t[i], ends && (i == t.len() - 1), typed, st);
	endtask

	task automatic add_cfg(input logic idx, input logic [6:0] value);
		stim_row_t r;
		r.op = ROW_CFG;
		r.reg_idx = idx;
		r.data = {1'b0, value};
		r.last = 1'b0;
		r.typed = 1'b0;
		r.st = ST_VALID;
		dir_rows.push_back(r);
	endtask

	// Receiver: random stalls per item, plus one long hold-off on request.
	initial begin
		int stall;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
			end
			stall = rx_idle_on ? $urandom_range(15, 0) : 0;
			if ($urandom_range(39, 0) == 0) rx_idle_on = !rx_idle_on;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			verdicts_seen++;
			if (verdict_q.size() == 0) begin
				err_cnt++;
				$display("%0t: unexpected item, expected none, actual m_tdata 0x%02h",
					$time, m_tdata);
			end else begin
				if (m_tdata[0] !== verdict_q[0].ok) begin
					err_cnt++;
					$display("%0t: is_valid mismatch, expected %0b, actual %0b",
						$time, verdict_q[0].ok, m_tdata[0]);
				end
				if (m_tdata[2:1] !== verdict_q[0].st) begin
					err_cnt++;
					$display("%0t: status mismatch, expected %0d, actual %0d",
						$time, verdict_q[0].st, m_tdata[2:1]);
				end
				void'(verdict_q.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d verdicts pending",
				$time, cycle_cnt, verdict_q.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int         lo, hi, phase_start;
		logic [6:0] p_min, p_max;
		static int  phase_min [7] = '{15, 4, 4, 64, 64, 20, 0};
		static int  phase_max [7] = '{34, 64, 4, 64, 4, 30, 0};

		arst_n = 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		min_len = MIN_LENGTH_RESET;
		max_len = MAX_LENGTH_RESET;
		char_cnt = 0;
		rem_acc = 0;
		bad_seen = 1'b0;

		// Directed rows. A lone byte right after reset is too short for the default range.
		add_byte(CH_ZERO, 1'b1, 1'b1, ST_BAD_LENGTH);
		add_cfg(REG_MIN_LENGTH, 7'd4);
		add_cfg(REG_MAX_LENGTH, 7'd64);
		add_text("0001", 1'b1, 1'b1, ST_VALID);
		// A space after the held bytes is skipped but still counts toward the length.
		add_text("0001 ", 1'b1, 1'b1, ST_VALID);
		add_text("Az09Z", 1'b1, 1'b0, ST_VALID);
		add_text(" 001", 1'b1, 1'b1, ST_BAD_CHAR);
		add_text("0001", 1'b0, 1'b0, ST_VALID);
		add_byte(8'hFF, 1'b1, 1'b1, ST_BAD_CHAR);
		// Bad length wins over a bad character.
		add_byte(8'h7E, 1'b1, 1'b1, ST_BAD_LENGTH);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].op == ROW_CFG) begin
				wait_drained();
				write_reg(dir_rows[i].reg_idx, dir_rows[i].data[6:0]);
			end else begin
				push_char(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].st);
			end
		end

		for (int p = 0; p < 7; p++) begin
			wait_drained();
			p_min = (phase_min[p] == 0) ? 7'($urandom_range(64, 4)) : 7'(phase_min[p]);
			p_max = (phase_max[p] == 0) ? 7'($urandom_range(64, 4)) : 7'(phase_max[p]);
			write_reg(REG_MIN_LENGTH, p_min);
			write_reg(REG_MAX_LENGTH, p_max);
			settings_used++;
			lo = (p_min < p_max) ? p_min : p_max;
			hi = (p_min < p_max) ? p_max : p_min;
			if (p == 1) begin
				// Back-to-back short strings while the receiver holds off fill the block.
				tx_burst = 1'b1;
				rx_hold_req = 1'b1;
				repeat (60) begin
					make_string(4, 8);
					send_string();
				end
				tx_burst = 1'b0;
			end
			phase_start = chars_sent;
			while (chars_sent - phase_start < PHASE_CHARS) begin
				make_string(lo, hi);
				send_string();
				if ($urandom_range(19, 0) == 0) wait_drained();
			end
		end
		wait_drained();

		$display("Sent %0d bytes in %0d strings under %0d length settings; %0d verdicts checked,",
			chars_sent, strings_sent, settings_used, verdicts_seen);
		$display("including %0d long output hold-offs and a min-above-max setting.", holds_done);
		if (err_cnt == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
